// File: hdl/lsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared sizes, codes, types and helpers of the PC lease predictor.
// ----------------------------------------------------------------------------
package lsp_pkg;

    localparam int PRED_ENTRIES    = 64;
    localparam int SAMPLER_ENTRIES = 32;
    localparam int PCS_PER_ADDR    = 4;
    localparam int SLOT_ENTRIES    = SAMPLER_ENTRIES * PCS_PER_ADDR;

    localparam int PRED_AW = $clog2(PRED_ENTRIES);
    localparam int SAMP_AW = $clog2(SAMPLER_ENTRIES);
    localparam int SLOT_AW = $clog2(SLOT_ENTRIES);
    localparam int PCS_AW  = (PCS_PER_ADDR > 1) ? $clog2(PCS_PER_ADDR) : 1;

    localparam logic [15:0] DEFAULT_LEASE_RST = 16'd16;
    localparam logic [15:0] MAX_LIFETIME_RST  = 16'd20000;

    // operation codes
    localparam logic [1:0] OP_LEASE = 2'd0;
    localparam logic [1:0] OP_TRACK = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_PRED_FULL = 2'd1;
    localparam logic [1:0] STATUS_SAMP_FULL = 2'd2;

    // configuration register indexes
    localparam logic CFG_DEFAULT_LEASE = 1'b0;
    localparam logic CFG_MAX_LIFETIME  = 1'b1;

    typedef struct packed {
        logic [15:0] default_lease;
        logic [15:0] max_lifetime;
    } t_cfg;

    typedef struct packed {
        logic is_lease;
        logic is_track;
        logic is_end;
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] pc;
        logic [31:0] address;
        logic [31:0] time_now;
    } t_item;

    typedef struct packed {
        logic [15:0] predicted_lifetime;
        logic [1:0]  status;
        logic [2:0]  updated_count;
    } t_result;

    function automatic logic [PRED_AW-1:0] pred_first(input logic [PRED_ENTRIES-1:0] v);
        logic [PRED_AW-1:0] idx;
        idx = '0;
        for (int i = PRED_ENTRIES - 1; i >= 0; i--) begin
            if (v[i]) idx = PRED_AW'(i);
        end
        return idx;
    endfunction

    function automatic logic [SAMP_AW-1:0] samp_first(input logic [SAMPLER_ENTRIES-1:0] v);
        logic [SAMP_AW-1:0] idx;
        idx = '0;
        for (int i = SAMPLER_ENTRIES - 1; i >= 0; i--) begin
            if (v[i]) idx = SAMP_AW'(i);
        end
        return idx;
    endfunction

endpackage

// File: hdl/pc_sampled_lease_predictor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pc_sampled_lease_predictor_top
// Per-PC lease predictor with an address sampler, queue interfaces both sides.
// ----------------------------------------------------------------------------
// Channel  | Handshake          | Payload
// input    | push / full        | i_operation, i_pc, i_address, i_time_now
// result   | pop / empty        | o_predicted_lifetime, o_status, o_updated_count
// config   | i_cfg_we           | i_cfg_idx, i_cfg_wdata
//
// Sequencer steps per word: a lease request looks up the PC and, if it is
// known, reads its prediction; a track load walks the address's slots in the
// slot RAMs; a lifetime end walks the slots and does a read-modify-write of
// the prediction RAM for each tracked PC.
// Reset is synchronous, active low; valid bits clear at once, no clearing pass.
// The input queue holds two words, so push proceeds while a result waits.
// The sequencer holds in its final step until the result register frees up.
// ----------------------------------------------------------------------------
module pc_sampled_lease_predictor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_pc,
    input  logic [31:0] i_address,
    input  logic [31:0] i_time_now,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_predicted_lifetime,
    output logic [1:0]  o_status,
    output logic [2:0]  o_updated_count,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);
    import lsp_pkg::*;

    t_cfg    r_cfg;
    logic    r_res_valid;
    t_result r_res;

    logic    w_valid;
    t_item   w_item;
    logic    w_take;
    logic    w_bres_valid;
    t_result w_bres;
    logic    w_res_ready;

    // configuration registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.default_lease <= DEFAULT_LEASE_RST;
            r_cfg.max_lifetime  <= MAX_LIFETIME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEFAULT_LEASE: r_cfg.default_lease <= i_cfg_wdata;
                CFG_MAX_LIFETIME:  r_cfg.max_lifetime  <= i_cfg_wdata;
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    lsp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_operation (i_operation),
        .i_pc        (i_pc),
        .i_address   (i_address),
        .i_time_now  (i_time_now),
        .o_valid     (w_valid),
        .o_item      (w_item),
        .i_take      (w_take)
    );

    lsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (w_valid),
        .i_item      (w_item),
        .o_take      (w_take),
        .o_res_valid (w_bres_valid),
        .o_res       (w_bres),
        .i_res_ready (w_res_ready)
    );

    // result register: free when empty or being popped
    assign w_res_ready = !r_res_valid || pop;

    always_ff @(posedge i_clk) begin
        if (w_bres_valid && w_res_ready) r_res <= w_bres;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_res_valid <= w_bres_valid;
        end
    end

    assign empty                = !r_res_valid;
    assign o_predicted_lifetime = r_res.predicted_lifetime;
    assign o_status             = r_res.status;
    assign o_updated_count      = r_res.updated_count;
endmodule

// File: hdl/lsp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/lsp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_front
// Input word queue: accept, decode the operation, hold two words for the back.
// ----------------------------------------------------------------------------
module lsp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  logic [1:0]     i_operation,
    input  logic [31:0]    i_pc,
    input  logic [31:0]    i_address,
    input  logic [31:0]    i_time_now,
    output logic           o_valid,
    output lsp_pkg::t_item o_item,
    input  logic           i_take
);
    import lsp_pkg::*;

    t_item       r_mem [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_cnt;
    t_item       w_item;
    logic        w_push;
    logic        w_pop;

    always_comb begin
        w_item          = '0;
        w_item.pc       = i_pc;
        w_item.address  = i_address;
        w_item.time_now = i_time_now;
        case (i_operation)
            OP_LEASE: w_item.kind.is_lease = 1'b1;
            OP_TRACK: w_item.kind.is_track = 1'b1;
            OP_END:   w_item.kind.is_end   = 1'b1;
            default:  w_item.kind          = '0;
        endcase
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wptr] <= w_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_push) r_wptr <= ~r_wptr;
            if (w_pop)  r_rptr <= ~r_rptr;
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

// File: hdl/lsp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_back
// Prediction table, address sampler and slot store with their sequencer.
// ----------------------------------------------------------------------------
module lsp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lsp_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    input  lsp_pkg::t_item   i_item,
    output logic             o_take,
    output logic             o_res_valid,
    output lsp_pkg::t_result o_res,
    input  logic             i_res_ready
);
    import lsp_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_FIND    = 4'd1;
    localparam logic [3:0] ST_LR_RD   = 4'd2;
    localparam logic [3:0] ST_TK_RD   = 4'd3;
    localparam logic [3:0] ST_TK_CHK  = 4'd4;
    localparam logic [3:0] ST_END_RD  = 4'd5;
    localparam logic [3:0] ST_END_CMP = 4'd6;
    localparam logic [3:0] ST_END_ENC = 4'd7;
    localparam logic [3:0] ST_END_UPD = 4'd8;
    localparam logic [3:0] ST_END_FIN = 4'd9;
    localparam logic [3:0] ST_DONE    = 4'd10;

    localparam logic [PCS_AW-1:0] K_LAST = PCS_AW'(PCS_PER_ADDR - 1);

    logic [3:0]                 r_state;
    t_item                      r_item;
    logic [PRED_ENTRIES-1:0]    r_pred_valid;
    logic [31:0]                r_pred_tag [PRED_ENTRIES];
    logic [SAMPLER_ENTRIES-1:0] r_samp_valid;
    logic [31:0]                r_samp_addr [SAMPLER_ENTRIES];
    logic [SLOT_ENTRIES-1:0]    r_slot_valid;
    logic [PRED_ENTRIES-1:0]    r_pmatch;
    logic [SAMPLER_ENTRIES-1:0] r_smatch;
    logic [SAMP_AW-1:0]         r_e;
    logic [PCS_AW-1:0]          r_k;
    logic [PCS_AW-1:0]          r_free_k;
    logic                       r_free_found;
    logic [PRED_AW-1:0]         r_pidx;
    logic [31:0]                r_life;
    t_result                    r_res;

    logic [PRED_ENTRIES-1:0]    w_pmatch_in;
    logic [PRED_ENTRIES-1:0]    w_pmatch_slot;
    logic [SAMPLER_ENTRIES-1:0] w_smatch_in;
    logic [PRED_AW-1:0]         w_pidx;
    logic [PRED_AW-1:0]         w_pfree;
    logic [SAMP_AW-1:0]         w_sidx;
    logic [SAMP_AW-1:0]         w_sfree;
    logic [SLOT_AW-1:0]         w_slot_base;
    logic [SLOT_AW-1:0]         w_slot_idx;
    logic [SLOT_AW-1:0]         w_slot_widx;
    logic [SLOT_AW-1:0]         w_new_base;
    logic                       w_f_found;
    logic [PCS_AW-1:0]          w_f_k;
    logic [31:0]                w_slot_pc;
    logic [31:0]                w_slot_start;
    logic [15:0]                w_pred_rdata;
    logic                       w_pred_we;
    logic [PRED_AW-1:0]         w_pred_waddr;
    logic [15:0]                w_pred_wdata;
    logic                       w_slot_we;
    logic                       w_gt;
    logic                       w_lt;
    logic [16:0]                w_nv17;
    logic [15:0]                w_nv;

    // tag compares: two per prediction entry, one per sampler entry
    always_comb begin
        for (int i = 0; i < PRED_ENTRIES; i++) begin
            w_pmatch_in[i]   = r_pred_valid[i] && (r_pred_tag[i] == i_item.pc);
            w_pmatch_slot[i] = r_pred_valid[i] && (r_pred_tag[i] == w_slot_pc);
        end
        for (int j = 0; j < SAMPLER_ENTRIES; j++) begin
            w_smatch_in[j] = r_samp_valid[j] && (r_samp_addr[j] == i_item.address);
        end
    end

    assign w_pidx      = pred_first(r_pmatch);
    assign w_pfree     = pred_first(~r_pred_valid);
    assign w_sidx      = samp_first(r_smatch);
    assign w_sfree     = samp_first(~r_samp_valid);
    assign w_slot_base = SLOT_AW'(r_e) * SLOT_AW'(PCS_PER_ADDR);
    assign w_slot_idx  = w_slot_base + SLOT_AW'(r_k);
    assign w_new_base  = SLOT_AW'(w_sfree) * SLOT_AW'(PCS_PER_ADDR);
    assign w_f_found   = r_free_found || !r_slot_valid[w_slot_idx];
    assign w_f_k       = r_free_found ? r_free_k : r_k;
    assign w_slot_widx = w_slot_base + SLOT_AW'(w_f_k);

    // step the prediction one toward the measured lifetime, then clamp
    assign w_gt   = {16'd0, w_pred_rdata} > r_life;
    assign w_lt   = {16'd0, w_pred_rdata} < r_life;
    assign w_nv17 = w_gt ? ({1'b0, w_pred_rdata} - 17'd1) : ({1'b0, w_pred_rdata} + 17'd1);
    always_comb begin
        if (w_nv17 > {1'b0, i_cfg.max_lifetime}) begin
            w_nv = i_cfg.max_lifetime;
        end else if (w_nv17 < {1'b0, i_cfg.default_lease}) begin
            w_nv = i_cfg.default_lease;
        end else begin
            w_nv = w_nv17[15:0];
        end
    end

    always_comb begin
        w_pred_we    = 1'b0;
        w_pred_waddr = w_pfree;
        w_pred_wdata = i_cfg.default_lease;
        if (r_state == ST_FIND && r_item.kind.is_lease && !(|r_pmatch)
                && !(&r_pred_valid)) begin
            w_pred_we = 1'b1;
        end else if (r_state == ST_END_UPD && (w_gt || w_lt)) begin
            w_pred_we    = 1'b1;
            w_pred_waddr = r_pidx;
            w_pred_wdata = w_nv;
        end
    end

    assign w_slot_we = (r_state == ST_TK_CHK)
                       && !(r_slot_valid[w_slot_idx] && (w_slot_pc == r_item.pc))
                       && (r_k == K_LAST) && w_f_found;

    lsp_ram #(.WIDTH(16), .DEPTH(PRED_ENTRIES)) u_pred_life (
        .i_clk   (i_clk),
        .i_we    (w_pred_we),
        .i_waddr (w_pred_waddr),
        .i_wdata (w_pred_wdata),
        .i_raddr (w_pidx),
        .o_rdata (w_pred_rdata)
    );

    lsp_ram #(.WIDTH(32), .DEPTH(SLOT_ENTRIES)) u_slot_pc (
        .i_clk   (i_clk),
        .i_we    (w_slot_we),
        .i_waddr (w_slot_widx),
        .i_wdata (r_item.pc),
        .i_raddr (w_slot_idx),
        .o_rdata (w_slot_pc)
    );

    lsp_ram #(.WIDTH(32), .DEPTH(SLOT_ENTRIES)) u_slot_start (
        .i_clk   (i_clk),
        .i_we    (w_slot_we),
        .i_waddr (w_slot_widx),
        .i_wdata (r_item.time_now),
        .i_raddr (w_slot_idx),
        .o_rdata (w_slot_start)
    );

    assign o_take      = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = r_res;

    // tags and sampler addresses: no reset, guarded by valid bits
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIND && r_item.kind.is_lease && !(|r_pmatch)
                && !(&r_pred_valid)) begin
            r_pred_tag[w_pfree] <= r_item.pc;
        end
        if (r_state == ST_FIND && r_item.kind.is_track && !(|r_smatch)
                && !(&r_samp_valid)) begin
            r_samp_addr[w_sfree] <= r_item.address;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_item   <= i_item;
                r_pmatch <= w_pmatch_in;
                r_smatch <= w_smatch_in;
                r_res    <= '0;
            end
            ST_FIND: begin
                r_k          <= '0;
                r_free_found <= 1'b0;
                r_e          <= (|r_smatch) ? w_sidx : w_sfree;
                if (r_item.kind.is_lease && !(|r_pmatch)) begin
                    r_res.predicted_lifetime <= i_cfg.default_lease;
                    if (&r_pred_valid) r_res.status <= STATUS_PRED_FULL;
                end
                if (r_item.kind.is_track && !(|r_smatch) && (&r_samp_valid)) begin
                    r_res.status <= STATUS_SAMP_FULL;
                end
            end
            ST_LR_RD: r_res.predicted_lifetime <= w_pred_rdata;
            ST_TK_CHK: begin
                r_free_found <= w_f_found;
                r_free_k     <= w_f_k;
                r_k          <= r_k + PCS_AW'(1);
                if (!(r_slot_valid[w_slot_idx] && (w_slot_pc == r_item.pc))
                        && (r_k == K_LAST) && !w_f_found) begin
                    r_res.status <= STATUS_SAMP_FULL;
                end
            end
            ST_END_RD: begin
                if (!r_slot_valid[w_slot_idx]) r_k <= r_k + PCS_AW'(1);
            end
            ST_END_CMP: begin
                r_pmatch <= w_pmatch_slot;
                r_life   <= r_item.time_now - w_slot_start;
            end
            ST_END_ENC: begin
                r_pidx <= w_pidx;
                if (!(|r_pmatch)) r_k <= r_k + PCS_AW'(1);
            end
            ST_END_UPD: begin
                r_k <= r_k + PCS_AW'(1);
                if (w_gt || w_lt) r_res.updated_count <= r_res.updated_count + 3'd1;
            end
            default: r_k <= r_k;
        endcase
    end

    // control: state and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pred_valid <= '0;
            r_samp_valid <= '0;
            r_slot_valid <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) r_state <= ST_FIND;
                end
                ST_FIND: begin
                    r_state <= ST_DONE;
                    if (r_item.kind.is_lease) begin
                        if (|r_pmatch) begin
                            r_state <= ST_LR_RD;
                        end else if (!(&r_pred_valid)) begin
                            r_pred_valid[w_pfree] <= 1'b1;
                        end
                    end else if (r_item.kind.is_track) begin
                        if (|r_smatch) begin
                            r_state <= ST_TK_RD;
                        end else if (!(&r_samp_valid)) begin
                            r_samp_valid[w_sfree] <= 1'b1;
                            for (int j = 0; j < PCS_PER_ADDR; j++) begin
                                r_slot_valid[w_new_base + SLOT_AW'(j)] <= 1'b0;
                            end
                            r_state <= ST_TK_RD;
                        end
                    end else if (r_item.kind.is_end) begin
                        if (|r_smatch) r_state <= ST_END_RD;
                    end
                end
                ST_LR_RD: r_state <= ST_DONE;
                ST_TK_RD: r_state <= ST_TK_CHK;
                ST_TK_CHK: begin
                    if (r_slot_valid[w_slot_idx] && (w_slot_pc == r_item.pc)) begin
                        r_state <= ST_DONE;
                    end else if (r_k == K_LAST) begin
                        if (w_f_found) r_slot_valid[w_slot_widx] <= 1'b1;
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_TK_RD;
                    end
                end
                ST_END_RD: begin
                    if (r_slot_valid[w_slot_idx]) begin
                        r_slot_valid[w_slot_idx] <= 1'b0;
                        r_state <= ST_END_CMP;
                    end else if (r_k == K_LAST) begin
                        r_state <= ST_END_FIN;
                    end
                end
                ST_END_CMP: r_state <= ST_END_ENC;
                ST_END_ENC: begin
                    if (|r_pmatch) begin
                        r_state <= ST_END_UPD;
                    end else begin
                        r_state <= (r_k == K_LAST) ? ST_END_FIN : ST_END_RD;
                    end
                end
                ST_END_UPD: r_state <= (r_k == K_LAST) ? ST_END_FIN : ST_END_RD;
                ST_END_FIN: begin
                    r_samp_valid[r_e] <= 1'b0;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (i_res_ready) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_pred_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pred_we |-> (r_state == ST_FIND || r_state == ST_END_UPD))
        else $error("prediction write outside insert or update");

    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && i_res_ready) |=> (r_state == ST_IDLE))
        else $error("sequencer did not release after result taken");

    a_take_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_valid) |=> (r_state == ST_FIND))
        else $error("accepted word did not enter lookup");

    a_slot_write_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_slot_we |-> r_item.kind.is_track)
        else $error("slot write for a non-track word");
`endif
endmodule

// File: bench/tb_pc_sampled_lease_predictor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pc_sampled_lease_predictor_top
// Self-checking bench for the PC lease predictor.
// A behavioral model of the prediction table, the address sampler and the
// slots predicts one result word per input word. Words go in through the
// push/full side and come out through the pop/empty side, with random gaps on
// both sides. A short table of directed words comes first. The random part
// follows, in phases with different clamp settings.
// ----------------------------------------------------------------------------
module tb_pc_sampled_lease_predictor_top;
    import lsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] pc;
        logic [31:0] address;
        logic [31:0] time_now;
        logic        has_lit;      // expected value typed in below
        logic [15:0] lit_life;
        logic [1:0]  lit_status;
        logic [2:0]  lit_count;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_operation;
    logic [31:0] i_pc;
    logic [31:0] i_address;
    logic [31:0] i_time_now;
    logic        empty;
    logic        pop;
    logic [15:0] o_predicted_lifetime;
    logic [1:0]  o_status;
    logic [2:0]  o_updated_count;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [15:0] i_cfg_wdata;

    pc_sampled_lease_predictor_top u_top (.*);

    // Model state of the lease predictor
    logic [15:0] lease_floor;
    logic [15:0] lease_ceiling;
    logic        pt_valid [PRED_ENTRIES];
    logic [31:0] pt_tag   [PRED_ENTRIES];
    logic [15:0] pt_life  [PRED_ENTRIES];
    logic        sa_valid [SAMPLER_ENTRIES];
    logic [31:0] sa_addr  [SAMPLER_ENTRIES];
    logic        sl_valid [SLOT_ENTRIES];
    logic [31:0] sl_pc    [SLOT_ENTRIES];
    logic [31:0] sl_start [SLOT_ENTRIES];

    t_result pending_results[$];
    int      error_count;
    int      words_in;
    int      words_out;
    int      idle_cycles;
    int      pop_idle_pct;
    bit      pop_hold;
    int      pop_hold_len;
    int      table_full_count, sampler_full_count, update_count_sum;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic int find_pc(logic [31:0] pc);
        for (int i = 0; i < PRED_ENTRIES; i++)
            if (pt_valid[i] && pt_tag[i] == pc) return i;
        return -1;
    endfunction

    function automatic int find_addr(logic [31:0] a);
        for (int i = 0; i < SAMPLER_ENTRIES; i++)
            if (sa_valid[i] && sa_addr[i] == a) return i;
        return -1;
    endfunction

    function automatic t_result predict_lease(logic [1:0] op, logic [31:0] pc,
                                              logic [31:0] a, logic [31:0] now);
        t_result r;
        int e, p, base, free_slot;
        logic [31:0] life, cur, nv;
        logic [2:0] cnt;
        r = '0;
        cnt = '0;
        free_slot = -1;
        case (op)
            OP_LEASE: begin
                p = find_pc(pc);
                if (p >= 0) begin
                    r.predicted_lifetime = pt_life[p];
                end else begin
                    r.predicted_lifetime = lease_floor;
                    for (int i = 0; i < PRED_ENTRIES; i++)
                        if (!pt_valid[i] && p < 0) p = i;
                    if (p >= 0) begin
                        pt_valid[p] = 1'b1;
                        pt_tag[p] = pc;
                        pt_life[p] = lease_floor;
                    end else begin
                        r.status = STATUS_PRED_FULL;
                    end
                end
            end
            OP_TRACK: begin
                e = find_addr(a);
                if (e < 0) begin
                    for (int i = 0; i < SAMPLER_ENTRIES; i++)
                        if (!sa_valid[i] && e < 0) e = i;
                    if (e >= 0) begin
                        sa_valid[e] = 1'b1;
                        sa_addr[e] = a;
                        for (int k = 0; k < PCS_PER_ADDR; k++)
                            sl_valid[e * PCS_PER_ADDR + k] = 1'b0;
                    end
                end
                if (e < 0) begin
                    r.status = STATUS_SAMP_FULL;
                end else begin
                    base = e * PCS_PER_ADDR;
                    for (int k = 0; k < PCS_PER_ADDR; k++) begin
                        if (sl_valid[base + k]) begin
                            if (sl_pc[base + k] == pc) return r;
                        end else if (free_slot < 0) begin
                            free_slot = base + k;
                        end
                    end
                    if (free_slot < 0) begin
                        r.status = STATUS_SAMP_FULL;
                    end else begin
                        sl_valid[free_slot] = 1'b1;
                        sl_pc[free_slot] = pc;
                        sl_start[free_slot] = now;
                    end
                end
            end
            OP_END: begin
                e = find_addr(a);
                if (e >= 0) begin
                    base = e * PCS_PER_ADDR;
                    for (int k = 0; k < PCS_PER_ADDR; k++) begin
                        if (sl_valid[base + k]) begin
                            sl_valid[base + k] = 1'b0;
                            p = find_pc(sl_pc[base + k]);
                            if (p >= 0) begin
                                life = now - sl_start[base + k];
                                cur = {16'd0, pt_life[p]};
                                if (cur != life) begin
                                    nv = (cur > life) ? cur - 1 : cur + 1;
                                    // upper clamp wins when the clamps cross
                                    if (nv > {16'd0, lease_ceiling})
                                        nv = {16'd0, lease_ceiling};
                                    else if (nv < {16'd0, lease_floor})
                                        nv = {16'd0, lease_floor};
                                    pt_life[p] = nv[15:0];
                                    cnt++;
                                end
                            end
                        end
                    end
                    sa_valid[e] = 1'b0;
                    r.updated_count = cnt;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: pop with random gaps, check against the oldest expectation
    // ------------------------------------------------------------------------
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (pop_hold_len > 0) begin
                pop_hold_len--;
                pop <= 1'b0;
            end else begin
                pop <= pop_hold ? 1'b0 : ($urandom_range(99) >= pop_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && pop && !empty) begin
            words_out++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word life=%0d status=%0d count=%0d", $realtime,
                         o_predicted_lifetime, o_status, o_updated_count);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_predicted_lifetime !== want.predicted_lifetime) begin
                    $display("%0t: predicted_lifetime expected %0d actual %0d", $realtime,
                             want.predicted_lifetime, o_predicted_lifetime);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $realtime,
                             want.status, o_status);
                    error_count++;
                end
                if (o_updated_count !== want.updated_count) begin
                    $display("%0t: updated_count expected %0d actual %0d", $realtime,
                             want.updated_count, o_updated_count);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: count cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d words outstanding",
                     pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    int push_idle_pct;

    // Offer one word, hold it until accepted, predict it on acceptance;
    // push stays as it is on return, the next word or the drain drives it
    task automatic send_word(logic [1:0] op, logic [31:0] pc, logic [31:0] a,
                             logic [31:0] now, output t_result got);
        while (push_idle_pct > 0 && $urandom_range(99) < push_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_operation <= op;
        i_pc <= pc;
        i_address <= a;
        i_time_now <= now;
        do @(posedge i_clk); while (full);
        got = predict_lease(op, pc, a, now);
        pending_results.push_back(got);
        words_in++;
        if (got.status == STATUS_PRED_FULL) table_full_count++;
        if (got.status == STATUS_SAMP_FULL) sampler_full_count++;
        update_count_sum += got.updated_count;
        @(negedge i_clk);
    endtask

    // Drop push, wait until every expected word has come, then let the
    // block settle
    task automatic drain();
        push <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_DEFAULT_LEASE) lease_floor = value;
        else lease_ceiling = value;
    endtask

    // PCs and addresses come from small pools so that hits, refills and
    // lifetime ends on tracked addresses are common
    function automatic logic [31:0] pick_pc(int pool);
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'hFFFF_FFFF - $urandom_range(3);
            default: return 32'h0040_0000 + 4 * $urandom_range(pool - 1);
        endcase
    endfunction

    function automatic logic [31:0] pick_addr(int pool);
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'hFFFF_FFC0 + $urandom_range(3);
            default: return 32'h8000_0000 + 64 * $urandom_range(pool - 1);
        endcase
    endfunction

    task automatic random_phase(int count, int pc_pool, int addr_pool, int base_now);
        t_result got;
        logic [31:0] now;
        int r;
        now = base_now;
        for (int n = 0; n < count; n++) begin
            now = now + $urandom_range(40);
            r = $urandom_range(99);
            if (r < 30) send_word(OP_LEASE, pick_pc(pc_pool), $urandom, $urandom, got);
            else if (r < 65) send_word(OP_TRACK, pick_pc(pc_pool), pick_addr(addr_pool),
                                       now, got);
            else if (r < 95) send_word(OP_END, $urandom, pick_addr(addr_pool),
                                       ($urandom_range(19) == 0) ? $urandom : now, got);
            else send_word(OP_UNUSED, $urandom, $urandom, $urandom, got);
        end
    endtask

    // Directed table: typed-in values only where they are obvious
    t_row directed[] = '{
        '{OP_LEASE, 32'h0000_0000, 32'h0, 32'h0, 1'b1, 16'd16, STATUS_OK, 3'd0},
        '{OP_LEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'd16, STATUS_OK, 3'd0},
        '{OP_LEASE, 32'h0000_0000, 32'h0, 32'h0, 1'b1, 16'd16, STATUS_OK, 3'd0},
        '{OP_END, 32'h0, 32'h1234_0000, 32'd100, 1'b1, 16'd0, STATUS_OK, 3'd0},
        '{OP_TRACK, 32'h0000_0000, 32'h1000_0000, 32'd10, 1'b1, 16'd0, STATUS_OK, 3'd0},
        '{OP_TRACK, 32'h0000_0000, 32'h1000_0000, 32'd90, 1'b1, 16'd0, STATUS_OK, 3'd0},
        '{OP_TRACK, 32'hFFFF_FFFF, 32'h1000_0000, 32'd20, 1'b1, 16'd0, STATUS_OK, 3'd0},
        '{OP_TRACK, 32'h0000_0004, 32'h1000_0000, 32'd30, 1'b1, 16'd0, STATUS_OK, 3'd0},
        '{OP_TRACK, 32'h0000_0008, 32'h1000_0000, 32'd40, 1'b1, 16'd0, STATUS_OK, 3'd0},
        '{OP_TRACK, 32'h0000_000C, 32'h1000_0000, 32'd50, 1'b1, 16'd0, STATUS_SAMP_FULL,
          3'd0},
        '{OP_END, 32'h0, 32'h1000_0000, 32'd1000, 1'b0, 16'd0, STATUS_OK, 3'd0},
        '{OP_LEASE, 32'h0000_0000, 32'h0, 32'h0, 1'b1, 16'd17, STATUS_OK, 3'd0},
        '{OP_TRACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 1'b1, 16'd0, STATUS_OK,
          3'd0},
        '{OP_END, 32'h0, 32'hFFFF_FFFF, 32'h0000_0005, 1'b0, 16'd0, STATUS_OK, 3'd0},
        '{OP_TRACK, 32'h0000_0000, 32'h2000_0000, 32'd100, 1'b1, 16'd0, STATUS_OK, 3'd0},
        '{OP_END, 32'h0, 32'h2000_0000, 32'd100, 1'b0, 16'd0, STATUS_OK, 3'd0},
        '{OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'd0, STATUS_OK,
          3'd0},
        '{OP_END, 32'h0, 32'h1000_0000, 32'd5, 1'b1, 16'd0, STATUS_OK, 3'd0}
    };

    initial begin
        t_result got;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_operation = OP_LEASE;
        i_pc = '0;
        i_address = '0;
        i_time_now = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_DEFAULT_LEASE;
        i_cfg_wdata = '0;
        error_count = 0;
        words_in = 0;
        words_out = 0;
        idle_cycles = 0;
        pop_idle_pct = 22;
        push_idle_pct = 22;
        pop_hold = 1'b0;
        pop_hold_len = 0;
        table_full_count = 0;
        sampler_full_count = 0;
        update_count_sum = 0;
        lease_floor = DEFAULT_LEASE_RST;
        lease_ceiling = MAX_LIFETIME_RST;
        for (int i = 0; i < PRED_ENTRIES; i++) pt_valid[i] = 1'b0;
        for (int i = 0; i < SAMPLER_ENTRIES; i++) sa_valid[i] = 1'b0;
        for (int i = 0; i < SLOT_ENTRIES; i++) sl_valid[i] = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words against reset settings
        foreach (directed[n]) begin
            send_word(directed[n].op, directed[n].pc, directed[n].address,
                      directed[n].time_now, got);
            if (directed[n].has_lit &&
                got !== t_result'{directed[n].lit_life, directed[n].lit_status,
                                  directed[n].lit_count}) begin
                $display("%0t: directed row %0d expected life=%0d status=%0d count=%0d",
                         $realtime, n, directed[n].lit_life, directed[n].lit_status,
                         directed[n].lit_count);
                error_count++;
            end
        end
        drain();

        // Stall the receiver for a long stretch while words keep coming
        pop_hold_len = 300;
        random_phase(20, 8, 4, 1000);
        drain();

        // No idling on either side
        pop_idle_pct = 0;
        push_idle_pct = 0;
        random_phase(80, 12, 6, 5000);
        drain();
        pop_idle_pct = 22;
        push_idle_pct = 22;

        // Narrow window: small floor and ceiling keep the clamps active
        write_cfg(CFG_DEFAULT_LEASE, 16'd0);
        write_cfg(CFG_MAX_LIFETIME, 16'd1);
        random_phase(80, 10, 6, 0);
        drain();

        // Extremes, then crossed clamps
        write_cfg(CFG_DEFAULT_LEASE, 16'hFFFF);
        write_cfg(CFG_MAX_LIFETIME, 16'hFFFF);
        random_phase(60, 10, 6, 32'hFFFF_FF00);
        drain();
        write_cfg(CFG_DEFAULT_LEASE, 16'd300);
        write_cfg(CFG_MAX_LIFETIME, 16'd40);
        random_phase(60, 10, 6, 200);
        drain();

        // Back to typical settings; wide pools fill the sampler and then the
        // prediction table
        write_cfg(CFG_DEFAULT_LEASE, 16'($urandom_range(255)));
        write_cfg(CFG_MAX_LIFETIME, 16'd20000);
        random_phase(130, 90, 48, 0);
        drain();
        random_phase(120, 20, 10, 70000);

        drain();
        $display("Covered %0d words in, %0d out: %0d table-full, %0d sampler-full,",
                 words_in, words_out, table_full_count, sampler_full_count);
        $display("%0d prediction updates across several clamp settings", update_count_sum);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", error_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
